### rtl/core/i2cm_pkg.sv
// Shared types, phase codes, command codes and register map of the I2C master bit engine.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int unsigned PH_W = 4;

  localparam logic [PH_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PH_W-1:0] PH_S_HIGH  = 4'd1;
  localparam logic [PH_W-1:0] PH_S_EDGE  = 4'd2;
  localparam logic [PH_W-1:0] PH_P_LOW   = 4'd3;
  localparam logic [PH_W-1:0] PH_P_HIGH  = 4'd4;
  localparam logic [PH_W-1:0] PH_W_LOW   = 4'd5;
  localparam logic [PH_W-1:0] PH_W_HIGH  = 4'd6;
  localparam logic [PH_W-1:0] PH_W_TAIL  = 4'd7;
  localparam logic [PH_W-1:0] PH_R_LOW   = 4'd8;
  localparam logic [PH_W-1:0] PH_R_HIGH  = 4'd9;
  localparam logic [PH_W-1:0] PH_A_LOW   = 4'd10;
  localparam logic [PH_W-1:0] PH_A_HIGH  = 4'd11;
  localparam logic [PH_W-1:0] PH_A_TAIL  = 4'd12;
  localparam logic [PH_W-1:0] PH_K_SETUP = 4'd13;
  localparam logic [PH_W-1:0] PH_K_POLL  = 4'd14;
  localparam logic [PH_W-1:0] PH_K_HOLD  = 4'd15;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;

  localparam logic [2:0] REG_START_HOLD  = 3'd0;
  localparam logic [2:0] REG_EDGE_HOLD   = 3'd1;
  localparam logic [2:0] REG_HALF_BIT    = 3'd2;
  localparam logic [2:0] REG_SAMPLE_HOLD = 3'd3;
  localparam logic [2:0] REG_POLL_LIMIT  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_hold_ticks;
    logic [7:0] edge_hold_ticks;
    logic [7:0] half_bit_ticks;
    logic [7:0] sample_hold_ticks;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic [3:0]      bit_cnt;
    logic [7:0]      tick_cnt;
    logic [7:0]      poll_cnt;
    logic [7:0]      shift;
    logic            ack_choice;
    logic            scl;
    logic            sda;
    logic            sda_oe;
    logic            ack_err;
    logic [7:0]      rx_hold;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    start_hold_ticks:  8'd8,
    edge_hold_ticks:   8'd4,
    half_bit_ticks:    8'd2,
    sample_hold_ticks: 8'd1,
    ack_poll_limit:    8'd100
  };

  localparam state_t STATE_RESET = '{
    phase:      PH_IDLE,
    bit_cnt:    4'd0,
    tick_cnt:   8'd0,
    poll_cnt:   8'd0,
    shift:      8'd0,
    ack_choice: 1'b0,
    scl:        1'b1,
    sda:        1'b1,
    sda_oe:     1'b1,
    ack_err:    1'b0,
    rx_hold:    8'd0
  };

endpackage

### rtl/core/i2cm_step.sv
// Next-state and result logic of the I2C master bit engine for one item.
`timescale 1ns / 1ps
module i2cm_step (
  input  i2cm_pkg::state_t    st,
  input  i2cm_pkg::cfg_t      cfg,
  input  i2cm_pkg::in_item_t  item,
  output i2cm_pkg::state_t    st_nxt,
  output i2cm_pkg::out_item_t res
);

  logic [7:0] lim;
  logic [7:0] tick_inc;
  logic       hit;
  logic [7:0] poll_inc;
  logic [3:0] bit_inc;
  logic [7:0] shift_w;
  logic       done;
  logic       rej;
  logic       is_cmd;

  assign tick_inc = st.tick_cnt + 8'd1;
  assign poll_inc = st.poll_cnt + 8'd1;
  assign bit_inc  = st.bit_cnt + 4'd1;
  assign shift_w  = {st.shift[6:0], 1'b0};
  assign hit      = (tick_inc >= lim);
  assign is_cmd   = item.cmd inside {[i2cm_pkg::CMD_START:i2cm_pkg::CMD_ACK]};

  always_comb begin
    case (st.phase)
      i2cm_pkg::PH_S_HIGH: lim = cfg.start_hold_ticks;
      i2cm_pkg::PH_S_EDGE,
      i2cm_pkg::PH_P_LOW,
      i2cm_pkg::PH_P_HIGH: lim = cfg.edge_hold_ticks;
      i2cm_pkg::PH_R_HIGH: lim = cfg.sample_hold_ticks;
      default:             lim = cfg.half_bit_ticks;
    endcase
  end

  always_comb begin
    st_nxt = st;
    done   = 1'b0;
    rej    = 1'b0;
    if (st.phase == i2cm_pkg::PH_IDLE) begin
      case (item.cmd)
        i2cm_pkg::CMD_START: begin
          st_nxt.scl    = 1'b1;
          st_nxt.sda    = 1'b1;
          st_nxt.sda_oe = 1'b1;
          st_nxt.phase  = i2cm_pkg::PH_S_HIGH;
        end
        i2cm_pkg::CMD_STOP: begin
          st_nxt.scl    = 1'b0;
          st_nxt.sda    = 1'b0;
          st_nxt.sda_oe = 1'b1;
          st_nxt.phase  = i2cm_pkg::PH_P_LOW;
        end
        i2cm_pkg::CMD_WRITE: begin
          st_nxt.shift   = item.tx_byte;
          st_nxt.bit_cnt = 4'd0;
          st_nxt.scl     = 1'b0;
          st_nxt.sda_oe  = 1'b1;
          st_nxt.sda     = item.tx_byte[7];
          st_nxt.phase   = i2cm_pkg::PH_W_LOW;
        end
        i2cm_pkg::CMD_READ: begin
          st_nxt.shift      = 8'd0;
          st_nxt.bit_cnt    = 4'd0;
          st_nxt.ack_choice = item.send_ack;
          st_nxt.scl        = 1'b0;
          st_nxt.sda_oe     = 1'b0;
          st_nxt.sda        = 1'b1;
          st_nxt.phase      = i2cm_pkg::PH_R_LOW;
        end
        i2cm_pkg::CMD_ACK: begin
          st_nxt.poll_cnt = 8'd0;
          st_nxt.scl      = 1'b0;
          st_nxt.sda_oe   = 1'b0;
          st_nxt.sda      = 1'b1;
          st_nxt.phase    = i2cm_pkg::PH_K_SETUP;
        end
        default: ;
      endcase
      st_nxt.tick_cnt = 8'd0;
    end else begin
      rej = is_cmd;
      if (st.phase != i2cm_pkg::PH_K_POLL) begin
        st_nxt.tick_cnt = hit ? 8'd0 : tick_inc;
      end
      case (st.phase)
        i2cm_pkg::PH_S_HIGH: if (hit) begin
          st_nxt.sda   = 1'b0;
          st_nxt.phase = i2cm_pkg::PH_S_EDGE;
        end
        i2cm_pkg::PH_S_EDGE: if (hit) begin
          st_nxt.scl   = 1'b0;
          done         = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_IDLE;
        end
        i2cm_pkg::PH_P_LOW: if (hit) begin
          st_nxt.scl   = 1'b1;
          st_nxt.sda   = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_P_HIGH;
        end
        i2cm_pkg::PH_P_HIGH: if (hit) begin
          done         = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_IDLE;
        end
        i2cm_pkg::PH_W_LOW: if (hit) begin
          st_nxt.scl   = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_W_HIGH;
        end
        i2cm_pkg::PH_W_HIGH: if (hit) begin
          st_nxt.scl   = 1'b0;
          st_nxt.phase = i2cm_pkg::PH_W_TAIL;
        end
        i2cm_pkg::PH_W_TAIL: if (hit) begin
          st_nxt.shift   = shift_w;
          st_nxt.bit_cnt = bit_inc;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            st_nxt.sda   = 1'b0;
            done         = 1'b1;
            st_nxt.phase = i2cm_pkg::PH_IDLE;
          end else begin
            st_nxt.sda   = shift_w[7];
            st_nxt.phase = i2cm_pkg::PH_W_LOW;
          end
        end
        i2cm_pkg::PH_R_LOW: if (hit) begin
          st_nxt.scl   = 1'b1;
          st_nxt.shift = {st.shift[6:0], item.sda_level};
          st_nxt.phase = i2cm_pkg::PH_R_HIGH;
        end
        i2cm_pkg::PH_R_HIGH: if (hit) begin
          st_nxt.scl     = 1'b0;
          st_nxt.bit_cnt = bit_inc;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            st_nxt.rx_hold = st.shift;
            st_nxt.sda_oe  = 1'b1;
            st_nxt.sda     = ~st.ack_choice;
            st_nxt.phase   = i2cm_pkg::PH_A_LOW;
          end else begin
            st_nxt.phase   = i2cm_pkg::PH_R_LOW;
          end
        end
        i2cm_pkg::PH_A_LOW: if (hit) begin
          st_nxt.scl   = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_A_HIGH;
        end
        i2cm_pkg::PH_A_HIGH: if (hit) begin
          st_nxt.scl   = 1'b0;
          st_nxt.sda   = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_A_TAIL;
        end
        i2cm_pkg::PH_A_TAIL: if (hit) begin
          done         = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_IDLE;
        end
        i2cm_pkg::PH_K_SETUP: if (hit) begin
          st_nxt.scl      = 1'b1;
          st_nxt.poll_cnt = 8'd0;
          st_nxt.phase    = i2cm_pkg::PH_K_POLL;
        end
        i2cm_pkg::PH_K_POLL: begin
          if (!item.sda_level) begin
            st_nxt.ack_err  = 1'b0;
            st_nxt.tick_cnt = 8'd0;
            st_nxt.phase    = i2cm_pkg::PH_K_HOLD;
          end else begin
            st_nxt.poll_cnt = poll_inc;
            if (poll_inc >= cfg.ack_poll_limit) begin
              st_nxt.ack_err  = 1'b1;
              st_nxt.scl      = 1'b0;
              done            = 1'b1;
              st_nxt.tick_cnt = 8'd0;
              st_nxt.phase    = i2cm_pkg::PH_IDLE;
            end
          end
        end
        i2cm_pkg::PH_K_HOLD: if (hit) begin
          st_nxt.scl   = 1'b0;
          done         = 1'b1;
          st_nxt.phase = i2cm_pkg::PH_IDLE;
        end
        default: begin
          st_nxt.tick_cnt = 8'd0;
          st_nxt.phase    = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_level  = st_nxt.scl;
    res.sda_drive  = st_nxt.sda_oe ? st_nxt.sda : 1'b1;
    res.sda_enable = st_nxt.sda_oe;
    res.busy_res   = (st_nxt.phase != i2cm_pkg::PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = st_nxt.rx_hold;
    res.ack_error  = st_nxt.ack_err;
    res.rejected   = rej;
  end

endmodule

### rtl/core/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: input register, state, result register, APB registers.
//
//   port group   direction  transfer
//   in_*         input      one tick or command per transfer (in_item_t)
//   out_*        output     one pin/status result per transfer (out_item_t)
//   APB          slave      five 8-bit timing registers at byte offsets 0x00..0x10
//
// Input register, then result register; one item per cycle unless out_ready stalls.
// The input register and the result register decouple the two channels; the engine state
// advances in the cycle an item moves from the input register into the result register.
// rst_n is synchronous, active low; the state and timing registers return to reset values.
// A stall on out_ready holds the result and fills the input register, then drops in_ready.
`timescale 1ns / 1ps
module i2c_master_bit_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  i2cm_pkg::in_item_t  in_q_r;
  logic                in_vld_r;
  i2cm_pkg::out_item_t out_q_r;
  logic                out_vld_r;
  i2cm_pkg::state_t    st_r;
  i2cm_pkg::state_t    st_nxt;
  i2cm_pkg::cfg_t      cfg_r;
  i2cm_pkg::out_item_t res;
  logic                advance;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  i2cm_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_q_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= i2cm_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
    if (advance) begin
      out_q_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= i2cm_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        i2cm_pkg::REG_START_HOLD:  cfg_r.start_hold_ticks  <= pwdata[7:0];
        i2cm_pkg::REG_EDGE_HOLD:   cfg_r.edge_hold_ticks   <= pwdata[7:0];
        i2cm_pkg::REG_HALF_BIT:    cfg_r.half_bit_ticks    <= pwdata[7:0];
        i2cm_pkg::REG_SAMPLE_HOLD: cfg_r.sample_hold_ticks <= pwdata[7:0];
        i2cm_pkg::REG_POLL_LIMIT:  cfg_r.ack_poll_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      i2cm_pkg::REG_START_HOLD:  prdata = {24'd0, cfg_r.start_hold_ticks};
      i2cm_pkg::REG_EDGE_HOLD:   prdata = {24'd0, cfg_r.edge_hold_ticks};
      i2cm_pkg::REG_HALF_BIT:    prdata = {24'd0, cfg_r.half_bit_ticks};
      i2cm_pkg::REG_SAMPLE_HOLD: prdata = {24'd0, cfg_r.sample_hold_ticks};
      i2cm_pkg::REG_POLL_LIMIT:  prdata = {24'd0, cfg_r.ack_poll_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result register not loaded after advance");

  a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == i2cm_pkg::PH_IDLE) |-> (st_r.tick_cnt == 8'd0))
    else $error("tick counter not cleared in idle");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_cnt <= i2cm_pkg::BITS_PER_BYTE)
    else $error("bit counter out of range");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_q_r.done_res) |-> !out_q_r.busy_res)
    else $error("done reported while still busy");

  a_released_sda: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_q_r.sda_enable) |-> out_q_r.sda_drive)
    else $error("released SDA must read high");

endmodule

### tb/i2c_master_bit_engine_checker.sv
// Checker for the I2C master bit engine: tracks timing registers, predicts each result, compares.
`timescale 1ns / 1ps
module i2c_master_bit_engine_checker
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic      pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic      wrap_up,
  output int        fail_count
);

  cfg_t            timing;
  logic [PH_W-1:0] phase;
  logic [3:0]      bits_done;
  logic [7:0]      hold_cnt;
  logic [7:0]      poll_cnt;
  logic [7:0]      shifter;
  logic [7:0]      rx_last;
  logic            ack_pick;
  logic            scl;
  logic            sda;
  logic            sda_oe;
  logic            ack_err;

  out_item_t pending_pins[$];
  int        mismatches = 0;
  bit        wrapped = 1'b0;

  assign fail_count = mismatches;

  function automatic bit hold_over(input logic [7:0] span);
    hold_cnt = hold_cnt + 8'd1;
    if (hold_cnt >= span) begin
      hold_cnt = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void go(input logic [PH_W-1:0] next);
    phase    = next;
    hold_cnt = 8'd0;
  endfunction

  function automatic out_item_t advance(input in_item_t it);
    out_item_t r;
    logic      done;
    logic      rej;
    done = 1'b0;
    rej  = 1'b0;
    if (phase == PH_IDLE) begin
      case (it.cmd)
        CMD_START: begin
          scl = 1'b1; sda = 1'b1; sda_oe = 1'b1; go(PH_S_HIGH);
        end
        CMD_STOP: begin
          scl = 1'b0; sda = 1'b0; sda_oe = 1'b1; go(PH_P_LOW);
        end
        CMD_WRITE: begin
          shifter = it.tx_byte; bits_done = 4'd0;
          scl = 1'b0; sda_oe = 1'b1; sda = it.tx_byte[7];
          go(PH_W_LOW);
        end
        CMD_READ: begin
          shifter = 8'd0; bits_done = 4'd0; ack_pick = it.send_ack;
          scl = 1'b0; sda_oe = 1'b0; sda = 1'b1;
          go(PH_R_LOW);
        end
        CMD_ACK: begin
          poll_cnt = 8'd0;
          scl = 1'b0; sda_oe = 1'b0; sda = 1'b1;
          go(PH_K_SETUP);
        end
        default: ;
      endcase
    end else begin
      rej = (it.cmd >= CMD_START) && (it.cmd <= CMD_ACK);
      case (phase)
        PH_S_HIGH:
          if (hold_over(timing.start_hold_ticks)) begin
            sda = 1'b0; go(PH_S_EDGE);
          end
        PH_S_EDGE:
          if (hold_over(timing.edge_hold_ticks)) begin
            scl = 1'b0; done = 1'b1; go(PH_IDLE);
          end
        PH_P_LOW:
          if (hold_over(timing.edge_hold_ticks)) begin
            scl = 1'b1; sda = 1'b1; go(PH_P_HIGH);
          end
        PH_P_HIGH:
          if (hold_over(timing.edge_hold_ticks)) begin
            done = 1'b1; go(PH_IDLE);
          end
        PH_W_LOW:
          if (hold_over(timing.half_bit_ticks)) begin
            scl = 1'b1; go(PH_W_HIGH);
          end
        PH_W_HIGH:
          if (hold_over(timing.half_bit_ticks)) begin
            scl = 1'b0; go(PH_W_TAIL);
          end
        PH_W_TAIL:
          if (hold_over(timing.half_bit_ticks)) begin
            shifter   = shifter << 1;
            bits_done = bits_done + 4'd1;
            if (bits_done >= BITS_PER_BYTE) begin
              sda = 1'b0; done = 1'b1; go(PH_IDLE);
            end else begin
              sda = shifter[7]; go(PH_W_LOW);
            end
          end
        PH_R_LOW:
          if (hold_over(timing.half_bit_ticks)) begin
            scl     = 1'b1;
            shifter = {shifter[6:0], it.sda_level};
            go(PH_R_HIGH);
          end
        PH_R_HIGH:
          if (hold_over(timing.sample_hold_ticks)) begin
            scl       = 1'b0;
            bits_done = bits_done + 4'd1;
            if (bits_done >= BITS_PER_BYTE) begin
              rx_last = shifter;
              sda_oe  = 1'b1;
              sda     = !ack_pick;
              go(PH_A_LOW);
            end else begin
              go(PH_R_LOW);
            end
          end
        PH_A_LOW:
          if (hold_over(timing.half_bit_ticks)) begin
            scl = 1'b1; go(PH_A_HIGH);
          end
        PH_A_HIGH:
          if (hold_over(timing.half_bit_ticks)) begin
            scl = 1'b0; sda = 1'b1; go(PH_A_TAIL);
          end
        PH_A_TAIL:
          if (hold_over(timing.half_bit_ticks)) begin
            done = 1'b1; go(PH_IDLE);
          end
        PH_K_SETUP:
          if (hold_over(timing.half_bit_ticks)) begin
            scl = 1'b1; poll_cnt = 8'd0; go(PH_K_POLL);
          end
        PH_K_POLL:
          if (!it.sda_level) begin
            ack_err = 1'b0; go(PH_K_HOLD);
          end else begin
            poll_cnt = poll_cnt + 8'd1;
            if (poll_cnt >= timing.ack_poll_limit) begin
              ack_err = 1'b1; scl = 1'b0; done = 1'b1; go(PH_IDLE);
            end
          end
        PH_K_HOLD:
          if (hold_over(timing.half_bit_ticks)) begin
            scl = 1'b0; done = 1'b1; go(PH_IDLE);
          end
        default: go(PH_IDLE);
      endcase
    end
    r.scl_level  = scl;
    r.sda_drive  = sda_oe ? sda : 1'b1;
    r.sda_enable = sda_oe;
    r.busy_res   = (phase != PH_IDLE);
    r.done_res   = done;
    r.rx_byte    = rx_last;
    r.ack_error  = ack_err;
    r.rejected   = rej;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      timing    = CFG_RESET;
      phase     = PH_IDLE;
      bits_done = 4'd0;
      hold_cnt  = 8'd0;
      poll_cnt  = 8'd0;
      shifter   = 8'd0;
      rx_last   = 8'd0;
      ack_pick  = 1'b0;
      scl       = 1'b1;
      sda       = 1'b1;
      sda_oe    = 1'b1;
      ack_err   = 1'b0;
      pending_pins.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_START_HOLD:  timing.start_hold_ticks  = pwdata[7:0];
          REG_EDGE_HOLD:   timing.edge_hold_ticks   = pwdata[7:0];
          REG_HALF_BIT:    timing.half_bit_ticks    = pwdata[7:0];
          REG_SAMPLE_HOLD: timing.sample_hold_ticks = pwdata[7:0];
          REG_POLL_LIMIT:  timing.ack_poll_limit    = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_pins.size() == 0) begin
          if (mismatches < 10)
            $display("%0t result with nothing pending: %0h", $time, out_data);
          mismatches++;
        end else begin
          want = pending_pins.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_data.scl_level));
          check_field("sda_drive", 8'(want.sda_drive), 8'(out_data.sda_drive));
          check_field("sda_enable", 8'(want.sda_enable), 8'(out_data.sda_enable));
          check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
          check_field("rx_byte", want.rx_byte, out_data.rx_byte);
          check_field("ack_error", 8'(want.ack_error), 8'(out_data.ack_error));
          check_field("rejected", 8'(want.rejected), 8'(out_data.rejected));
        end
      end
      if (in_valid && in_ready)
        pending_pins.push_back(advance(in_data));
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (pending_pins.size() != 0) begin
          $display("%0d results never arrived", pending_pins.size());
          mismatches += pending_pins.size();
        end
      end
    end
  end

endmodule

### tb/i2c_master_bit_engine_top_tb.sv
// Testbench top for the I2C master bit engine: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module i2c_master_bit_engine_top_tb;
  import i2cm_pkg::*;

  localparam int         QUIET_LIMIT   = 5000;
  localparam int         LONG_HOLD     = 80;
  localparam int         SETTLE_ROUNDS = 1000;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        wrap_up = 1'b0;
  int          fail_count;

  cfg_t timing = CFG_RESET;
  int   send_pct = 0;
  int   stall_pct = 0;
  int   sent = 0;
  int   received = 0;
  int   hold_ask = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  int   quiet = 0;
  logic last_busy = 1'b0;

  i2c_master_bit_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2c_master_bit_engine_checker engine_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .wrap_up(wrap_up), .fail_count(fail_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      received  <= received + 1;
      last_busy <= out_data.busy_res;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_ask != hold_done) begin
      hold_done <= hold_ask;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 1 : int'(v);
  endfunction

  // ticks a command needs after its own transfer, assuming the ack arrives last
  function automatic int command_span(input logic [2:0] c);
    int half;
    half = at_least_one(timing.half_bit_ticks);
    case (c)
      CMD_START: return at_least_one(timing.start_hold_ticks) +
                        at_least_one(timing.edge_hold_ticks);
      CMD_STOP:  return 2 * at_least_one(timing.edge_hold_ticks);
      CMD_WRITE: return 24 * half;
      CMD_READ:  return 8 * (half + at_least_one(timing.sample_hold_ticks)) + 3 * half;
      CMD_ACK:   return 2 * half + at_least_one(timing.ack_poll_limit) + 1;
      default:   return 0;
    endcase
  endfunction

  function automatic in_item_t tick_item(input int pct_low);
    in_item_t it;
    it.cmd       = CMD_TICK;
    it.tx_byte   = 8'($urandom);
    it.send_ack  = 1'($urandom);
    it.sda_level = ($urandom_range(99) < pct_low) ? 1'b0 : 1'b1;
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (received != sent) @(posedge clk);
  endtask

  // finish any command in flight so the timing registers can change
  task automatic settle();
    int rounds;
    rounds = 0;
    drain();
    while (last_busy && rounds < SETTLE_ROUNDS) begin
      repeat (8) offer(tick_item(50));
      drain();
      rounds++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
    logic [23:0] junk;
    junk = 24'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_timing(input cfg_t c);
    settle();
    apb_write(REG_START_HOLD, c.start_hold_ticks);
    apb_write(REG_EDGE_HOLD, c.edge_hold_ticks);
    apb_write(REG_HALF_BIT, c.half_bit_ticks);
    apb_write(REG_SAMPLE_HOLD, c.sample_hold_ticks);
    apb_write(REG_POLL_LIMIT, c.ack_poll_limit);
    timing = c;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_pct = 54; stall_pct = 0;  end
      2:       begin send_pct = 0;  stall_pct = 54; end
      3:       begin send_pct = 9;  stall_pct = 9;  end
      default: begin send_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic run_command(input logic [2:0] c, input logic [7:0] tx, input logic ack,
                             input int pct_low, input bit cut_short, input bit noisy);
    in_item_t it;
    int       span;
    int       n;
    int       r;
    it          = tick_item(pct_low);
    it.cmd      = c;
    it.tx_byte  = tx;
    it.send_ack = ack;
    offer(it);
    span = command_span(c);
    n = cut_short ? $urandom_range(0, span) : span + $urandom_range(0, 2);
    repeat (n) begin
      it = tick_item(pct_low);
      r  = $urandom_range(99);
      if (noisy && r < 4)
        it.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else if (noisy && r < 7)
        it.cmd = 3'($urandom_range(CMD_START, CMD_ACK));
      offer(it);
    end
  endtask

  task automatic random_traffic(input int n_items, input int max_cmds);
    int       first;
    int       left;
    int       r;
    int       pct;
    logic [2:0] c;
    first = sent;
    left  = max_cmds;
    while (sent - first < n_items && left > 0) begin
      r = $urandom_range(0, 19);
      if (r < 15)
        c = 3'($urandom_range(CMD_START, CMD_ACK));
      else if (r < 17)
        c = CMD_TICK;
      else
        c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 5;
        2:       pct = 25;
        default: pct = 100;
      endcase
      if (c != CMD_ACK) pct = 50;
      run_command(c, 8'($urandom), 1'($urandom), pct, $urandom_range(99) < 15, 1'b1);
      left--;
    end
  endtask

  function automatic cfg_t small_timing();
    cfg_t c;
    c.start_hold_ticks  = 8'($urandom_range(0, 4));
    c.edge_hold_ticks   = 8'($urandom_range(0, 4));
    c.half_bit_ticks    = 8'($urandom_range(0, 4));
    c.sample_hold_ticks = 8'($urandom_range(0, 4));
    c.ack_poll_limit    = 8'($urandom_range(0, 6));
    return c;
  endfunction

  initial begin
    in_item_t it;
    cfg_t     c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short timing, every command and corner
    load_timing('{8'd1, 8'd1, 8'd1, 8'd1, 8'd2});
    run_command(CMD_UNUSED_LO, 8'h00, 1'b0, 50, 1'b0, 1'b0);
    run_command(CMD_UNUSED_HI, 8'hFF, 1'b1, 50, 1'b0, 1'b0);
    it = tick_item(50);
    it.cmd = CMD_START;
    offer(it);
    it.cmd = CMD_WRITE;
    offer(it);
    it.cmd = CMD_TICK;
    offer(it);
    offer(it);
    run_command(CMD_WRITE, 8'h00, 1'b0, 50, 1'b0, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b1, 50, 1'b0, 1'b0);
    run_command(CMD_ACK, 8'h5A, 1'b0, 100, 1'b0, 1'b0);
    run_command(CMD_ACK, 8'hA5, 1'b1, 0, 1'b0, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b1, 0, 1'b0, 1'b0);
    run_command(CMD_READ, 8'hFF, 1'b0, 100, 1'b0, 1'b0);
    run_command(CMD_STOP, 8'h3C, 1'b1, 50, 1'b0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      load_timing(small_timing());
      set_idling(p % 4);
      if (p == 4) begin
        hold_ask++;
        random_traffic(100, 1000);
      end else if (p == 5) begin
        random_traffic(50, 1000);
        drain();
        random_traffic(50, 1000);
      end else begin
        random_traffic(100, 1000);
      end
    end

    load_timing('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    set_idling(2);
    random_traffic(100, 1000);

    // longest start hold and acknowledge timeout
    c = small_timing();
    c.start_hold_ticks = 8'd255;
    c.ack_poll_limit   = 8'd255;
    load_timing(c);
    set_idling(3);
    run_command(CMD_START, 8'h00, 1'b0, 50, 1'b0, 1'b1);
    run_command(CMD_ACK, 8'h00, 1'b0, 0, 1'b0, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
